// ----- hw/rtl/twht_pkg.sv -----
// ----------------------------------------------------------------------------
// twht_pkg: shared types and constants of the two-way hash table
// Row layout, field widths, operation and register codes, set index helper.
// ----------------------------------------------------------------------------
`default_nettype none

package twht_pkg;

  // SETS is a power of two
  localparam int unsigned SETS       = 1024;
  localparam int unsigned WAYS       = 2;
  localparam int unsigned SET_W      = $clog2(SETS);

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned MOVE_W     = 20;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned BOUND_W    = 2;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned MASK_W     = 10;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_AGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL   = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = 10'd1023;

  // bits 53..0: age, bound, depth, score, move
  typedef struct packed {
    logic        [AGE_W-1:0]   age;
    logic        [BOUND_W-1:0] bound;
    logic        [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic        [MOVE_W-1:0]  move;
  } payload_t;

  typedef struct packed {
    payload_t           pl;
    logic [KEY_W-1:0]   key;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic                      hit;
    logic                      hit_way;
    logic        [MOVE_W-1:0]  move;
    logic signed [SCORE_W-1:0] score;
    logic        [DEPTH_W-1:0] depth;
    logic        [BOUND_W-1:0] bound;
  } res_t;

  typedef struct packed {
    logic we;
    row_t row;
    res_t res;
  } sel_t;

  // (key AND mask) modulo SETS
  function automatic logic [SET_W-1:0] set_of_key(input logic [KEY_W-1:0]  key,
                                                  input logic [MASK_W-1:0] mask);
    logic [MASK_W+SET_W-1:0] wide;
    wide = {{SET_W{1'b0}}, key[MASK_W-1:0] & mask};
    return wide[SET_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/twht_ram.sv -----
// ----------------------------------------------------------------------------
// twht_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module twht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/twht_way_sel.sv -----
// ----------------------------------------------------------------------------
// twht_way_sel: way selection and row update
// Picks fill or victim way on a store, builds the new row, forms the
// lookup result from the row read out of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module twht_way_sel
  import twht_pkg::*;
(
  input  wire row_t                       row_i,
  input  wire logic        [OP_W-1:0]     op_i,
  input  wire logic        [KEY_W-1:0]    key_i,
  input  wire logic        [DEPTH_W-1:0]  depth_i,
  input  wire logic signed [SCORE_W-1:0]  score_i,
  input  wire logic        [BOUND_W-1:0]  bound_i,
  input  wire logic        [MOVE_W-1:0]   move_i,
  input  wire logic                       enable_i,
  input  wire logic        [MOVE_W-1:0]   null_move_i,
  input  wire logic        [AGE_W-1:0]    age_i,
  output sel_t                            sel_o
);

  logic       fill0;
  logic       fill1;
  logic       fill;
  logic       victim;
  logic       slot;
  way_t       new_way;

  always_comb begin
    fill0  = (row_i[0].key == '0) || (row_i[0].key == key_i);
    fill1  = (row_i[1].key == '0) || (row_i[1].key == key_i);
    fill   = fill0 || fill1;
    victim = (row_i[1].pl.age >= row_i[0].pl.age) &&
             (row_i[1].pl.depth < row_i[0].pl.depth);
    slot   = fill0 ? 1'b0 : (fill1 ? 1'b1 : victim);

    new_way.key      = key_i;
    new_way.pl.age   = age_i;
    new_way.pl.bound = bound_i;
    new_way.pl.depth = depth_i;
    new_way.pl.score = score_i;
    // a null move on an empty or matching way keeps what was there
    new_way.pl.move  = (fill && (move_i == null_move_i)) ? row_i[slot].pl.move : move_i;

    sel_o     = '0;
    sel_o.row = row_i;
    case (op_i)
      OP_STORE: begin
        sel_o.we        = 1'b1;
        sel_o.row[slot] = new_way;
      end
      OP_LOOKUP: begin
        if (enable_i && ((row_i[0].key == key_i) || (row_i[1].key == key_i))) begin
          sel_o.res.hit     = 1'b1;
          sel_o.res.hit_way = (row_i[0].key != key_i);
          sel_o.res.move    = row_i[sel_o.res.hit_way].pl.move;
          sel_o.res.score   = row_i[sel_o.res.hit_way].pl.score;
          sel_o.res.depth   = row_i[sel_o.res.hit_way].pl.depth;
          sel_o.res.bound   = row_i[sel_o.res.hit_way].pl.bound;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/two_way_hash_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// two_way_hash_table_with_aging: two-way set-associative hash table
// Both ways of a set share one RAM row; read, update, write back.
// ----------------------------------------------------------------------------
// Flow: a request is registered as its row is read; the look state writes
//   a store back, loading the result register once it is free or emptied.
//   A request is taken only when idle (row read, then row write on the
//   single table RAM); a new request is taken while a result waits.
// Reset: a clearing pass zeroes every one of the SETS rows, during which
//   no request is taken; config writes work.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_hash_table_with_aging
  import twht_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic        [OP_W-1:0]     opcode_i,
  input  wire logic        [KEY_W-1:0]    hash_key_i,
  input  wire logic        [DEPTH_W-1:0]  search_depth_i,
  input  wire logic signed [SCORE_W-1:0]  entry_score_i,
  input  wire logic        [BOUND_W-1:0]  bound_kind_i,
  input  wire logic        [MOVE_W-1:0]   best_move_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            hit_o,
  output logic                            hit_way_o,
  output logic             [MOVE_W-1:0]   found_move_o,
  output logic signed      [SCORE_W-1:0]  found_score_o,
  output logic             [DEPTH_W-1:0]  found_depth_o,
  output logic             [BOUND_W-1:0]  found_bound_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [SET_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic                    enable_q;
  logic [MASK_W-1:0]       mask_q;
  logic [MOVE_W-1:0]       null_move_q;
  logic [AGE_W-1:0]        age_q, age_d;

  logic [OP_W-1:0]         op_q;
  logic [KEY_W-1:0]        key_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [BOUND_W-1:0]      bound_q;
  logic [MOVE_W-1:0]       move_q;
  logic [SET_W-1:0]        set_q;

  logic                    out_valid_q, out_valid_d;
  res_t                    res_q;

  logic                    accept;
  logic                    commit;
  logic                    ram_we;
  logic [SET_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        ram_rdata;
  logic [SET_W-1:0]        rd_set;
  sel_t                    sel;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // result register must be free, or emptied this cycle
  assign commit     = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  assign rd_set     = set_of_key(hash_key_i, mask_q);

  twht_ram #(
    .Width (ROW_W),
    .Depth (SETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_set),
    .rdata_o (ram_rdata)
  );

  twht_way_sel u_way_sel (
    .row_i       (row_t'(ram_rdata)),
    .op_i        (op_q),
    .key_i       (key_q),
    .depth_i     (depth_q),
    .score_i     (score_q),
    .bound_i     (bound_q),
    .move_i      (move_q),
    .enable_i    (enable_q),
    .null_move_i (null_move_q),
    .age_i       (age_q),
    .sel_o       (sel)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    age_d       = age_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = sel.row;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (commit) begin
          ram_we      = sel.we;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (op_q == OP_AGE) begin
            age_d = age_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      age_q       <= '0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b1;
      mask_q      <= MASK_RESET;
      null_move_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      age_q       <= age_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE: enable_q    <= cfg_data_i[0];
          CFG_MASK:   mask_q      <= cfg_data_i[MASK_W-1:0];
          CFG_NULL:   null_move_q <= cfg_data_i[MOVE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      key_q   <= hash_key_i;
      depth_q <= search_depth_i;
      score_q <= entry_score_i;
      bound_q <= bound_kind_i;
      move_q  <= best_move_i;
      set_q   <= rd_set;
    end
    if (commit) begin
      res_q <= sel.res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = res_q.hit;
  assign hit_way_o     = res_q.hit_way;
  assign found_move_o  = res_q.move;
  assign found_score_o = res_q.score;
  assign found_depth_o = res_q.depth;
  assign found_bound_o = res_q.bound;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-way hash table with aging
// A directed table, then phased random traffic over small key pools that
// collide in few sets. A local model of both ways predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import twht_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam int                   N_PHASES   = 6;
  localparam int                   PHASE_REQS = 310;
  localparam int                   MAX_REPORT = 40;
  localparam int                   DRAIN_WAIT = 4;

  localparam logic [KEY_W-1:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] K_HI   = 64'h8000_0000_0000_03FF;
  localparam logic [KEY_W-1:0] K_MID  = 64'h4000_0000_0000_03FF;

  localparam res_t NO_RES   = '0;
  localparam res_t ZERO_HIT = {1'b1, {($bits(res_t)-1){1'b0}}};

  typedef struct packed {
    logic        [OP_W-1:0]    op;
    logic        [KEY_W-1:0]   key;
    logic        [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic        [BOUND_W-1:0] bound;
    logic        [MOVE_W-1:0]  move;
  } tt_req_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CHECK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    tt_req_t               req;
    res_t                  res;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_we    = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_index = '0;
  logic       [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic        [OP_W-1:0]      opcode    = '0;
  logic        [KEY_W-1:0]     hash_key  = '0;
  logic        [DEPTH_W-1:0]   search_depth = '0;
  logic signed [SCORE_W-1:0]   entry_score  = '0;
  logic        [BOUND_W-1:0]   bound_kind   = '0;
  logic        [MOVE_W-1:0]    best_move    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        hit;
  logic                        hit_way;
  logic        [MOVE_W-1:0]    found_move;
  logic signed [SCORE_W-1:0]   found_score;
  logic        [DEPTH_W-1:0]   found_depth;
  logic        [BOUND_W-1:0]   found_bound;

  // local copy of the table
  logic [KEY_W-1:0]     key_mem [0:SETS*WAYS-1];
  payload_t             pl_mem  [0:SETS*WAYS-1];
  logic [AGE_W-1:0]     cur_age    = '0;
  logic                 cfg_enable = 1'b1;
  logic [MASK_W-1:0]    cfg_mask   = MASK_RESET;
  logic [MOVE_W-1:0]    cfg_null   = '0;

  res_t      lookup_results_q [$];
  plan_row_t plan_q [$];
  int        errors = 0;
  bit        calm   = 1'b0;

  always #5 clk = ~clk;

  two_way_hash_table_with_aging u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .hash_key_i     (hash_key),
    .search_depth_i (search_depth),
    .entry_score_i  (entry_score),
    .bound_kind_i   (bound_kind),
    .best_move_i    (best_move),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hit_o          (hit),
    .hit_way_o      (hit_way),
    .found_move_o   (found_move),
    .found_score_o  (found_score),
    .found_depth_o  (found_depth),
    .found_bound_o  (found_bound)
  );

  // applies one request to the local table, returns what the block should give
  function automatic res_t table_op_result(input tt_req_t r);
    res_t              res;
    int                base;
    int                slot;
    bit                fill;
    logic [MOVE_W-1:0] mv;
    res  = '0;
    base = 2 * int'(r.key[MASK_W-1:0] & cfg_mask);
    case (r.op)
      OP_STORE: begin
        fill = 1'b1;
        if (key_mem[base] == '0 || key_mem[base] == r.key) begin
          slot = base;
        end else if (key_mem[base+1] == '0 || key_mem[base+1] == r.key) begin
          slot = base + 1;
        end else begin
          fill = 1'b0;
          if (pl_mem[base+1].age >= pl_mem[base].age &&
              pl_mem[base+1].depth < pl_mem[base].depth) begin
            slot = base + 1;
          end else begin
            slot = base;
          end
        end
        // null move only keeps the old move on a fill, never on eviction
        mv = (fill && r.move == cfg_null) ? pl_mem[slot].move : r.move;
        key_mem[slot] = r.key;
        pl_mem[slot]  = '{age: cur_age, bound: r.bound, depth: r.depth,
                          score: r.score, move: mv};
      end
      OP_LOOKUP: begin
        if (cfg_enable) begin
          if (key_mem[base] == r.key) begin
            slot = base;
          end else if (key_mem[base+1] == r.key) begin
            slot = base + 1;
          end else begin
            slot = -1;
          end
          if (slot >= 0) begin
            res.hit     = 1'b1;
            res.hit_way = slot[0];
            res.move    = pl_mem[slot].move;
            res.score   = pl_mem[slot].score;
            res.depth   = pl_mem[slot].depth;
            res.bound   = pl_mem[slot].bound;
          end
        end
      end
      OP_AGE: cur_age = cur_age + 1'b1;
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_op(input row_kind_e k, input logic [OP_W-1:0] op,
                        input logic [KEY_W-1:0] key, input logic [DEPTH_W-1:0] d,
                        input logic [SCORE_W-1:0] s, input logic [BOUND_W-1:0] b,
                        input logic [MOVE_W-1:0] m, input res_t res);
    plan_row_t row;
    row      = '0;
    row.kind = k;
    row.req  = '{op: op, key: key, depth: d, score: s, bound: b, move: m};
    row.res  = res;
    plan_q.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    plan_q.push_back(row);
  endtask

  task automatic send_request(input tt_req_t r, input bit typed, input res_t typed_res);
    res_t pred;
    in_valid     <= 1'b1;
    opcode       <= r.op;
    hash_key     <= r.key;
    search_depth <= r.depth;
    entry_score  <= r.score;
    bound_kind   <= r.bound;
    best_move    <= r.move;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = table_op_result(r);
    lookup_results_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // only with the block drained, plus a wait for the last row write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: cfg_enable = data[0];
      CFG_MASK:   cfg_mask   = data[MASK_W-1:0];
      CFG_NULL:   cfg_null   = data[MOVE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic report(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: random back-pressure, one long hold-off, checking
  int n_results = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    res_t want;
    if (out_valid && out_ready) begin
      n_results++;
      if (lookup_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = lookup_results_q.pop_front();
        report("hit",         64'(want.hit),     64'(hit));
        report("hit_way",     64'(want.hit_way), 64'(hit_way));
        report("found_move",  64'(want.move),    64'(found_move));
        report("found_score", 64'(want.score),   64'(found_score));
        report("found_depth", 64'(want.depth),   64'(found_depth));
        report("found_bound", 64'(want.bound),   64'(found_bound));
      end
    end
    if (!hold_done && n_results >= 500) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    tt_req_t              r;
    logic [KEY_W-1:0]     pool [0:15];
    logic [MASK_W-1:0]    set_lo [0:3];
    logic [MASK_W-1:0]    ph_mask;
    logic [MOVE_W-1:0]    ph_null;
    int                   pick;
    int                   age_pct;

    for (int i = 0; i < SETS*WAYS; i++) begin
      key_mem[i] = '0;
      pl_mem[i]  = '0;
    end

    // directed table
    add_op(ROW_CHECK, OP_LOOKUP, 64'h5, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_CHECK, OP_LOOKUP, 64'h0, 8'd0, 16'd0, 2'd0, 20'd0, ZERO_HIT);
    add_op(ROW_CHECK, OP_STORE, K_ONES, 8'd255, 16'sd32767, 2'd3, 20'hFFFFF, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_ONES, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_CHECK, OP_STORE, K_HI, 8'd0, -16'sd32768, 2'd0, 20'd0, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_HI, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_CHECK, OP_AGE, 64'h0, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    // set full: third key evicts the shallower way
    add_op(ROW_REQ,   OP_STORE, K_MID, 8'd7, -16'sd99, 2'd2, 20'd12345, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_MID, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_HI, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_REQ,   OP_STORE, K_ONES, 8'd1, 16'sd5, 2'd1, 20'd0, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_ONES, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_CHECK, OP_UNUSED, K_ONES, 8'hFF, 16'hFFFF, 2'd3, 20'hFFFFF, NO_RES);
    add_op(ROW_REQ,   OP_STORE, 64'h0, 8'd200, -16'sd1, 2'd3, 20'hABCDE, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, 64'h0, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_cfg(CFG_ENABLE, 20'd0);
    add_op(ROW_CHECK, OP_LOOKUP, K_ONES, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_CHECK, OP_STORE, K_HI, 8'd9, 16'sd77, 2'd1, 20'h11111, NO_RES);
    add_cfg(CFG_ENABLE, 20'd1);
    add_cfg(CFG_MASK, 20'd0);
    add_op(ROW_REQ,   OP_STORE, 64'h123, 8'd10, 16'sd100, 2'd1, 20'h54321, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, 64'h123, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_cfg(CFG_MASK, 20'd1023);
    add_cfg(CFG_NULL, 20'hFFFFF);
    add_op(ROW_REQ,   OP_STORE, K_ONES, 8'd3, 16'sd0, 2'd0, 20'hFFFFF, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_ONES, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_op(ROW_REQ,   OP_LOOKUP, K_HI, 8'd0, 16'd0, 2'd0, 20'd0, NO_RES);
    add_cfg(CFG_SPARE, 20'hFFFFF);
    add_cfg(CFG_NULL, 20'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        cfg_write(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_request(plan_q[i].req, plan_q[i].kind == ROW_CHECK, plan_q[i].res);
        maybe_pause();
      end
    end

    // random phases; each starts drained with a fresh setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin ph_mask = 10'd1023; ph_null = 20'd0;               end
        1: begin ph_mask = 10'd0;    ph_null = 20'hFFFFF;           end
        2: begin ph_mask = 10'd3;    ph_null = MOVE_W'($urandom);   end
        3: begin ph_mask = 10'd1023; ph_null = 20'd0;               end
        4: begin ph_mask = 10'd15;   ph_null = MOVE_W'($urandom);   end
        default: begin ph_mask = MASK_W'($urandom); ph_null = 20'hFFFFF; end
      endcase
      cfg_write(CFG_ENABLE, {1'($urandom_range(0, 1)), 18'd0, 1'(ph != 3)});
      cfg_write(CFG_MASK,   {10'($urandom_range(0, 1023)), ph_mask});
      cfg_write(CFG_NULL,   ph_null);
      calm    = (ph == 2);
      age_pct = (ph == 4) ? 50 : 12;

      for (int i = 0; i < 4; i++) set_lo[i] = MASK_W'($urandom);
      for (int i = 0; i < 16; i++) begin
        pool[i]           = {$urandom, $urandom};
        pool[i][MASK_W-1:0] = set_lo[i % 4];
      end
      pool[1] = K_ONES;
      if (ph < 2) pool[0] = '0;

      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)                   r.op = OP_UNUSED;
        else if (pick < 3 + age_pct)    r.op = OP_AGE;
        else if (pick < 3 + age_pct + (97 - age_pct) / 2) r.op = OP_STORE;
        else                            r.op = OP_LOOKUP;
        r.key   = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 15)]
                                               : {$urandom, $urandom};
        r.depth = DEPTH_W'($urandom);
        r.score = SCORE_W'($urandom);
        r.bound = BOUND_W'($urandom);
        r.move  = ($urandom_range(0, 99) < 20) ? cfg_null : MOVE_W'($urandom);
        send_request(r, 1'b0, NO_RES);
        maybe_pause();
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (lookup_results_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
